/* src/smte_pkg.sv */
package smte_pkg;

   // Operation codes carried in the op field of a request word.
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_LOAD    = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] skip_count;
      logic [15:0] take_count;
      logic [8:0]  tx_length;
      logic [7:0]  load_index;
      logic [15:0] load_data;
      logic        rx_ready;
      logic        tx_empty;
      logic        bus_error;
      logic [15:0] rx_data;
   } spi_req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [15:0] tx_data;
      logic        store_valid;
      logic [15:0] store_index;
      logic [15:0] store_data;
      logic        complete;
      logic [15:0] transferred;
      logic        status_cleared;
   } spi_rsp_type;

endpackage

/* src/spi_message_transfer_engine_unit.sv */
// A request word accepted at a clock edge has its response word registered at that same edge,
// with rsp_valid high from then on.
// Throughput: one request word per cycle. The only limit is the response register; while
// it holds an unaccepted word under rsp_stall, req_stall is raised.
// Reset (synchronous, active high) clears the cursors, counts, flags and response valid.
// The transmit store is not cleared and holds unknown data until it is loaded.
module spi_message_transfer_engine_unit #(
   parameter int TX_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  smte_pkg::spi_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output smte_pkg::spi_rsp_type rsp_word
);
   import smte_pkg::*;

   // Address width of the transmit store; a single-entry store still gets one address bit.
   localparam int ADDR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam logic [16:0] DEPTH_C = 17'(TX_DEPTH);
   localparam logic [16:0] LAST_C  = 17'(TX_DEPTH - 1);

   // Message state. The cursors never exceed the message length, which fits in 16 bits.
   logic [15:0] rx_pos_ff, rx_pos_in;
   logic [15:0] tx_pos_ff, tx_pos_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] take_ff, take_in;
   logic [8:0]  tx_count_ff, tx_count_in;
   logic        rx_active_ff, rx_active_in;
   logic        done_ff, done_in;

   // Response register and the registered read port of the transmit store.
   logic        rsp_valid_ff, rsp_valid_in;
   spi_rsp_type rsp_ff, rsp_in;
   logic [15:0] mem_q_ff;
   logic [15:0] tx_store_ff [TX_DEPTH];

   logic              accept;
   logic              do_load;
   logic              do_read;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [16:0]       rd_raw;
   logic [16:0]       sum_len;
   logic [16:0]       max_len;
   logic [16:0]       rx_off;

   // The block takes a new word whenever the response register is empty or being drained.
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // Message length is the larger of the transmit count and skip plus take, saturated.
   assign sum_len = {1'b0, req_word.skip_count} + {1'b0, req_word.take_count};
   assign max_len = ({8'd0, req_word.tx_length} > sum_len) ? {8'd0, req_word.tx_length}
                                                           : sum_len;

   // Offset of the current receive word within the take window.
   assign rx_off = {1'b0, rx_pos_ff} - {1'b0, skip_ff};

   // Transmit read address: the cursor inside the count, else the last valid word,
   // clamped to the last store entry.
   always_comb begin
      if (tx_pos_ff < {7'd0, tx_count_ff}) begin
         rd_raw = {1'b0, tx_pos_ff};
      end else begin
         rd_raw = {8'd0, tx_count_ff} - 17'd1;
      end
      if (rd_raw > LAST_C) begin
         rd_raw = LAST_C;
      end
   end
   assign rd_addr = rd_raw[ADDR_W-1:0];
   assign wr_addr = ADDR_W'({9'd0, req_word.load_index});

   assign do_load = accept && (req_word.op == OP_LOAD) &&
                    ({9'd0, req_word.load_index} < DEPTH_C);

   always_comb begin
      rx_pos_in    = rx_pos_ff;
      tx_pos_in    = tx_pos_ff;
      length_in    = length_ff;
      skip_in      = skip_ff;
      take_in      = take_ff;
      tx_count_in  = tx_count_ff;
      rx_active_in = rx_active_ff;
      done_in      = done_ff;
      do_read      = 1'b0;
      rsp_in       = '0;

      unique case (req_word.op)
         OP_START: begin
            // A start during an active receive is ignored.
            if (!rx_active_ff) begin
               skip_in     = req_word.skip_count;
               take_in     = req_word.take_count;
               tx_count_in = req_word.tx_length;
               length_in   = max_len[16] ? 16'hFFFF : max_len[15:0];
               rx_pos_in   = '0;
               tx_pos_in   = '0;
               rx_active_in = (max_len != '0);
               done_in      = (max_len == '0);
            end
         end
         OP_SERVICE: begin
            if (req_word.bus_error) begin
               // An error only clears the controller status; nothing moves.
               rsp_in.status_cleared = 1'b1;
            end else begin
               if (req_word.rx_ready && rx_active_ff) begin
                  if (!rx_off[16] && (rx_off[15:0] < take_ff)) begin
                     rsp_in.store_valid = 1'b1;
                     rsp_in.store_index = rx_off[15:0];
                     rsp_in.store_data  = req_word.rx_data;
                  end
                  rx_pos_in = rx_pos_ff + 16'd1;
                  if (rx_pos_in >= length_ff) begin
                     rx_active_in = 1'b0;
                     done_in      = 1'b1;
                  end
               end
               if (req_word.tx_empty && (tx_pos_ff < length_ff)) begin
                  // The word itself is read through the registered store port along with the response.
                  rsp_in.tx_valid = 1'b1;
                  do_read         = (tx_count_ff != '0);
                  tx_pos_in       = tx_pos_ff + 16'd1;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_in.complete    = done_in;
      rsp_in.transferred = (rx_pos_in < tx_pos_in) ? rx_pos_in : tx_pos_in;
      // The tx_data slot carries a flag that the store word is to be used.
      rsp_in.tx_data     = {15'd0, do_read};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_pos_ff    <= '0;
         tx_pos_ff    <= '0;
         length_ff    <= '0;
         skip_ff      <= '0;
         take_ff      <= '0;
         tx_count_ff  <= '0;
         rx_active_ff <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rx_pos_ff    <= rx_pos_in;
            tx_pos_ff    <= tx_pos_in;
            length_ff    <= length_in;
            skip_ff      <= skip_in;
            take_ff      <= take_in;
            tx_count_ff  <= tx_count_in;
            rx_active_ff <= rx_active_in;
            done_ff      <= done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload; loaded only when a word is accepted, so it holds under stall.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Transmit store: one write port for loads, one registered read port for service.
   always_ff @(posedge clock) begin
      if (do_load) begin
         tx_store_ff[wr_addr] <= req_word.load_data;
      end
      if (accept && do_read) begin
         mem_q_ff <= tx_store_ff[rd_addr];
      end
   end

   always_comb begin
      rsp_word         = rsp_ff;
      rsp_word.tx_data = rsp_ff.tx_data[0] ? mem_q_ff : 16'd0;
   end

   a_store_in_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.store_valid) |-> (rsp_ff.store_index < take_ff))
      else $error("stored word index lies outside the take window");

   a_active_not_done: assert property (@(posedge clock) disable iff (reset)
      rx_active_ff |-> !done_ff)
      else $error("message both active and complete");

   a_rx_pos_bound: assert property (@(posedge clock) disable iff (reset)
      rx_active_ff |-> (rx_pos_ff < length_ff))
      else $error("receive cursor reached length while still active");

   a_tx_pos_bound: assert property (@(posedge clock) disable iff (reset)
      tx_pos_ff <= length_ff)
      else $error("transmit cursor ran past the message length");

   a_tx_flag_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tx_data[0]) |-> rsp_ff.tx_valid)
      else $error("store read issued for a response without a transmit word");

endmodule

/* verif/tb.sv */
module tb;
   import smte_pkg::*;

   // Op code 3 has no meaning for the block: it must change nothing and only
   // report the status fields.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int STORE_DEPTH   = 256;
   localparam int RANDOM_WORDS  = 700;
   localparam int LONG_SERVICES = 150;
   localparam int CYCLE_LIMIT   = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   spi_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   spi_rsp_type rsp_word;

   spi_message_transfer_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The run is bounded by a cycle counter. Even the slowest legal run, with
   // every word waiting out the longest gaps on both sides, ends far below it.
   int unsigned cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[spi_message_transfer_engine_unit] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer model. It mirrors the state of the block: the transmit store,
   // both cursors, the message window and the busy and done flags. It is
   // advanced once per accepted request word, in acceptance order, and gives
   // the response word the block must produce for it.
   // ------------------------------------------------------------------------
   logic [15:0] tx_words [0:STORE_DEPTH-1];
   bit          word_written [0:STORE_DEPTH-1];
   logic [15:0] rx_pos_model = '0;
   logic [15:0] tx_pos_model = '0;
   logic [15:0] msg_len = '0;
   logic [15:0] skip_words = '0;
   logic [15:0] take_words = '0;
   logic [8:0]  tx_count = '0;
   bit          rx_busy = 1'b0;
   bit          msg_done = 1'b0;

   function automatic spi_rsp_type sequence_word(spi_req_type w);
      spi_rsp_type r;
      logic [16:0] total;
      logic [15:0] offset;
      logic [15:0] rd;
      r = '0;
      case (w.op)
         OP_START: begin
            // A start is ignored while the receive side is still busy.
            if (!rx_busy) begin
               total = 17'(w.skip_count) + 17'(w.take_count);
               if (17'(w.tx_length) > total) total = 17'(w.tx_length);
               if (total > 17'h0FFFF) total = 17'h0FFFF;
               skip_words   = w.skip_count;
               take_words   = w.take_count;
               tx_count     = w.tx_length;
               msg_len      = total[15:0];
               rx_pos_model = '0;
               tx_pos_model = '0;
               rx_busy      = (total != 17'd0);
               msg_done     = (total == 17'd0);
            end
         end
         OP_LOAD: begin
            tx_words[w.load_index]     = w.load_data;
            word_written[w.load_index] = 1'b1;
         end
         OP_SERVICE: begin
            if (w.bus_error) begin
               // An error only clears the status; neither cursor moves.
               r.status_cleared = 1'b1;
            end else begin
               if (w.rx_ready && rx_busy) begin
                  if (rx_pos_model >= skip_words) begin
                     offset = rx_pos_model - skip_words;
                     if (offset < take_words) begin
                        r.store_valid = 1'b1;
                        r.store_index = offset;
                        r.store_data  = w.rx_data;
                     end
                  end
                  rx_pos_model = rx_pos_model + 16'd1;
                  if (rx_pos_model >= msg_len) begin
                     rx_busy  = 1'b0;
                     msg_done = 1'b1;
                  end
               end
               if (w.tx_empty && tx_pos_model < msg_len) begin
                  // Past the transmit count the last word repeats; with no
                  // words at all the bus gets zeros.
                  if (tx_count != 9'd0) begin
                     rd = (tx_pos_model < 16'(tx_count)) ? tx_pos_model
                                                         : 16'(tx_count - 9'd1);
                     if (rd > 16'(STORE_DEPTH - 1)) rd = 16'(STORE_DEPTH - 1);
                     r.tx_data = tx_words[rd[7:0]];
                  end
                  r.tx_valid   = 1'b1;
                  tx_pos_model = tx_pos_model + 16'd1;
               end
            end
         end
         default: begin
         end
      endcase
      r.complete    = msg_done;
      r.transferred = (rx_pos_model < tx_pos_model) ? rx_pos_model : tx_pos_model;
      return r;
   endfunction

   // Responses owed by the block, oldest first.
   spi_rsp_type due_responses [$];

   int unsigned words_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned tx_seen = 0;
   int unsigned stores_seen = 0;
   int unsigned clears_seen = 0;
   int unsigned mismatches = 0;

   // ------------------------------------------------------------------------
   // Sender side. A word is offered with req_valid and held until it is taken
   // at an edge with req_stall low. Gaps come at random while send_gaps is set;
   // valid is only lowered inside such a gap and once the last test is done.
   // ------------------------------------------------------------------------
   bit send_gaps = 1'b0;

   task automatic send_word(spi_req_type w);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      due_responses.push_back(sequence_word(w));
      words_sent++;
   endtask

   // A word with every field random, so that fields the op does not use also
   // see both values of each bit. The transmit length stays in its range.
   function automatic spi_req_type scrambled_word(logic [1:0] op);
      logic [95:0] raw;
      spi_req_type w;
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(spi_req_type)-1:0];
      w.op = op;
      w.tx_length = 9'($urandom_range(0, 256));
      return w;
   endfunction

   task automatic send_load(logic [7:0] index, logic [15:0] data);
      spi_req_type w;
      w = scrambled_word(OP_LOAD);
      w.load_index = index;
      w.load_data  = data;
      send_word(w);
   endtask

   task automatic send_service(bit rx, bit tx, bit err, logic [15:0] data);
      spi_req_type w;
      w = scrambled_word(OP_SERVICE);
      w.rx_ready  = rx;
      w.tx_empty  = tx;
      w.bus_error = err;
      w.rx_data   = data;
      send_word(w);
   endtask

   // The transmit store powers up unknown, so before a message that will
   // really start, every entry it may read is loaded first.
   task automatic send_start(logic [15:0] skip, logic [15:0] take, logic [8:0] count);
      spi_req_type w;
      if (!rx_busy) begin
         for (int i = 0; i < count && i < STORE_DEPTH; i++) begin
            if (!word_written[i]) send_load(8'(i), 16'($urandom));
         end
      end
      w = scrambled_word(OP_START);
      w.skip_count = skip;
      w.take_count = take;
      w.tx_length  = count;
      send_word(w);
   endtask

   // One complete message: start, then service events until both cursors
   // have run out. Now and then a load, a start while busy, a bus error or
   // an unused op code is mixed in.
   task automatic run_message(logic [15:0] skip, logic [15:0] take, logic [8:0] count);
      int pick;
      send_start(skip, take, count);
      while (rx_busy || tx_pos_model < msg_len) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_load(8'($urandom), 16'($urandom));
         end else if (pick == 1 && rx_busy) begin
            send_word(scrambled_word(OP_START));
         end else if (pick <= 2) begin
            send_word(scrambled_word(OP_UNUSED));
         end else begin
            send_service($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                         $urandom_range(0, 15) == 0, 16'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver side. rsp_stall comes in random bursts while rsp_gaps is set.
   // A test may ask for a long hold-off by loading hold_cycles; this process
   // counts it down and keeps the output stalled meanwhile.
   // ------------------------------------------------------------------------
   bit rsp_gaps = 1'b0;
   int hold_cycles = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (rsp_gaps && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 7) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Response checker. Each word taken from the block is compared field by
   // field with the oldest owed response.
   // ------------------------------------------------------------------------
   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : check_responses
      spi_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_responses.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_word);
         end else begin
            want = due_responses.pop_front();
            responses_seen++;
            if (want.tx_valid) tx_seen++;
            if (want.store_valid) stores_seen++;
            if (want.status_cleared) clears_seen++;
            check_field("tx_valid", 16'(want.tx_valid), 16'(rsp_word.tx_valid));
            check_field("tx_data", want.tx_data, rsp_word.tx_data);
            check_field("store_valid", 16'(want.store_valid), 16'(rsp_word.store_valid));
            check_field("store_index", want.store_index, rsp_word.store_index);
            check_field("store_data", want.store_data, rsp_word.store_data);
            check_field("complete", 16'(want.complete), 16'(rsp_word.complete));
            check_field("transferred", want.transferred, rsp_word.transferred);
            check_field("status_cleared", 16'(want.status_cleared),
                        16'(rsp_word.status_cleared));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Hand-picked words: store extremes, the unused op, a zero-length message,
   // a start while busy, a bus error, receive after completion, transmit with
   // no words and transmit past the count.
   task automatic test_basic_sequences();
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      send_load(8'd0, 16'hFFFF);
      send_load(8'd255, 16'h0000);
      send_load(8'd1, 16'hA5A5);
      send_load(8'd2, 16'h5A5A);
      send_word(scrambled_word(OP_UNUSED));
      send_service(1'b1, 1'b1, 1'b0, 16'hFFFF);
      send_start(16'd0, 16'd0, 9'd0);
      // Length three: one word skipped, one stored, three sent.
      send_start(16'd1, 16'd1, 9'd3);
      send_start(16'hFFFF, 16'hFFFF, 9'd256);
      send_service(1'b1, 1'b1, 1'b1, 16'hFFFF);
      send_service(1'b1, 1'b1, 1'b0, 16'hFFFF);
      send_service(1'b1, 1'b0, 1'b0, 16'h1234);
      send_service(1'b0, 1'b1, 1'b0, 16'h0000);
      send_service(1'b1, 1'b1, 1'b0, 16'h8001);
      send_service(1'b1, 1'b1, 1'b0, 16'h7FFE);
      // No transmit words: the bus gets zeros.
      send_start(16'd0, 16'd2, 9'd0);
      send_service(1'b1, 1'b1, 1'b0, 16'hC3C3);
      send_service(1'b1, 1'b1, 1'b0, 16'h3C3C);
      // Two transmit words over a length of four: the second one repeats.
      send_start(16'd2, 16'd2, 9'd2);
      repeat (4) send_service(1'b1, 1'b1, 1'b0, 16'($urandom));
   endtask

   // A message that walks the whole transmit store up to its last entry.
   task automatic test_whole_store();
      send_gaps = 1'b1;
      rsp_gaps  = 1'b1;
      run_message(16'd0, 16'd4, 9'd256);
   endtask

   // Mostly well-formed messages of small random sizes, with some loose
   // words in between. Gaps on either side switch on and off per message.
   task automatic test_random_traffic();
      int unsigned stop_at;
      int pick;
      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         send_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps  = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 7);
         if (pick == 0) begin
            case ($urandom_range(0, 2))
               0: send_load(8'($urandom), 16'($urandom));
               1: send_word(scrambled_word(OP_UNUSED));
               default: send_service(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 16'($urandom));
            endcase
         end else begin
            run_message(16'($urandom_range(0, 6)), 16'($urandom_range(0, 10)),
                        ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 256))
                                                    : 9'($urandom_range(0, 12)));
         end
      end
   endtask

   // The output is held off for a long stretch while the sender keeps
   // offering words back to back, so the block has to stall its input.
   task automatic test_output_backpressure();
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      hold_cycles = 80;
      repeat (4) run_message(16'($urandom_range(0, 3)), 16'($urandom_range(1, 8)),
                             9'($urandom_range(1, 12)));
   endtask

   // Skip plus take overflows sixteen bits, so the length saturates. Such a
   // message is far too long to finish, so only its opening stretch is run,
   // with a start while busy thrown in. No gaps from here on.
   task automatic test_longest_message();
      spi_req_type w;
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      send_start(16'd1, 16'hFFFF, 9'd256);
      w = scrambled_word(OP_START);
      w.skip_count = 16'hFFFF;
      w.take_count = 16'hFFFF;
      w.tx_length  = 9'd256;
      send_word(w);
      repeat (LONG_SERVICES)
         send_service(1'b1, $urandom_range(0, 7) != 0, $urandom_range(0, 63) == 0,
                      16'($urandom));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_basic_sequences();
      test_whole_store();
      test_random_traffic();
      test_output_backpressure();
      test_longest_message();

      req_valid <= 1'b0;
      // Let every owed response come out, then a few more cycles in case the
      // block produces a stray one.
      while (due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d request words and checked %0d responses in %0d cycles.",
               words_sent, responses_seen, cycles);
      $display("Responses held %0d transmits, %0d stored words and %0d error clears.",
               tx_seen, stores_seen, clears_seen);
      if (mismatches == 0) begin
         $display("[spi_message_transfer_engine_unit] OK");
      end else begin
         $display("[spi_message_transfer_engine_unit] ERROR");
      end
      $finish;
   end

endmodule
